// ===== rtl/core/tdca_pkg.sv =====
// ---------------------------------------------------------------------------
// tdca_pkg
// Shared types, widths and codes of the dihedral copy address generator.
// ---------------------------------------------------------------------------
package tdca_pkg;

    // Field widths
    localparam int IDX_W       = 24;
    localparam int DATA_W      = 32;
    localparam int BATCH_CFG_W = 9;
    localparam int SIDE_CFG_W  = 6;
    localparam int CHAN_CFG_W  = 7;
    localparam int SYM_W       = 3;

    // Configuration bus
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Default size limits
    localparam int DEF_MAX_BATCH    = 256;
    localparam int DEF_MAX_SIDE     = 32;
    localparam int DEF_MAX_CHANNELS = 64;

    // Symmetry code bits
    localparam logic [SYM_W-1:0] SYM_TRANSPOSE = 3'h4;
    localparam logic [SYM_W-1:0] SYM_FLIP_X    = 3'h2;
    localparam logic [SYM_W-1:0] SYM_FLIP_Y    = 3'h1;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_BATCH_COUNT  = 3'd0,
        REG_HEIGHT       = 3'd1,
        REG_WIDTH        = 3'd2,
        REG_CHANNELS     = 3'd3,
        REG_CHANNEL_LAST = 3'd4,
        REG_SYMMETRY     = 3'd5,
        REG_REVERSE_MODE = 3'd6
    } reg_idx_t;

    // Decoded operating mode
    typedef struct packed {
        logic channel_last;
        logic tr;
        logic fx;
        logic fy;
    } mode_t;

    // Bits needed for a counter that runs 0 .. maxv-1
    function automatic int ctr_w(input int maxv);
        return (maxv > 1) ? $clog2(maxv) : 1;
    endfunction

endpackage

// ===== rtl/core/tensor_dihedral_copy_addresser_top.sv =====
// ---------------------------------------------------------------------------
// tensor_dihedral_copy_addresser_top
// Destination address generator for flip/transpose tensor copies.
// ---------------------------------------------------------------------------
// Takes one element per clock in source order while in_stall is low and
// returns its destination index under the programmed symmetry with the
// value passed through. A new request is accepted every cycle that
// in_stall is low; the result passes through the position stage and then
// the three chained multiply-add stages of the index computation. in_stall
// rises only when all four stages hold results and out_stall is high.
// Program the registers only while no requests are in flight.
// ---------------------------------------------------------------------------
module tensor_dihedral_copy_addresser_top
    import tdca_pkg::*;
#(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_W-1:0]     data_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      dest_index,
    output logic [DATA_W-1:0]     value_out,
    output logic                  last_item
);

    localparam int NB_W = $clog2(MAX_BATCH + 1);
    localparam int NS_W = $clog2(MAX_SIDE + 1);
    localparam int NC_W = $clog2(MAX_CHANNELS + 1);
    localparam int CB_W = ctr_w(MAX_BATCH);

    logic [NB_W-1:0]   nb;
    logic [NS_W-1:0]   nh, nw;
    logic [NC_W-1:0]   nc;
    mode_t             mode;
    logic              s1_valid, s1_last, s2_ready;
    logic [CB_W-1:0]   s1_b;
    logic [IDX_W-1:0]  s1_x, s1_y, s1_z;
    logic [DATA_W-1:0] s1_value;

    // Configuration registers
    tdca_cfg #(
        .MAX_BATCH    (MAX_BATCH),
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .nb      (nb),
        .nh      (nh),
        .nw      (nw),
        .nc      (nc),
        .mode    (mode)
    );

    // Position counters and coordinate stage
    tdca_coord #(
        .MAX_BATCH    (MAX_BATCH),
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .data_in  (data_in),
        .in_stall (in_stall),
        .s2_ready (s2_ready),
        .nb       (nb),
        .nh       (nh),
        .nw       (nw),
        .nc       (nc),
        .mode     (mode),
        .s1_valid (s1_valid),
        .s1_b     (s1_b),
        .s1_x     (s1_x),
        .s1_y     (s1_y),
        .s1_z     (s1_z),
        .s1_value (s1_value),
        .s1_last  (s1_last)
    );

    // Index multiply-add pipeline
    tdca_index #(
        .MAX_BATCH    (MAX_BATCH),
        .MAX_SIDE     (MAX_SIDE),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_index (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_b       (s1_b),
        .s1_x       (s1_x),
        .s1_y       (s1_y),
        .s1_z       (s1_z),
        .s1_value   (s1_value),
        .s1_last    (s1_last),
        .s2_ready   (s2_ready),
        .nh         (nh),
        .nw         (nw),
        .nc         (nc),
        .mode       (mode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dest_index (dest_index),
        .value_out  (value_out),
        .last_item  (last_item)
    );

    // Input back-pressure only comes from a stalled, full output
    a_stall_from_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("in_stall raised without a stalled output");

    // Every accepted request lands in the coordinate stage
    a_accept_fills_s1: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(in_valid && !in_stall && rst_n) |-> s1_valid
    ) else $error("accepted request missing from coordinate stage");

endmodule

// ===== rtl/core/tdca_cfg.sv =====
// ---------------------------------------------------------------------------
// tdca_cfg
// Register file on the APB port; clamps sizes and decodes the symmetry mode.
// ---------------------------------------------------------------------------
module tdca_cfg
    import tdca_pkg::*;
#(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int NB_W = $clog2(MAX_BATCH + 1),
    localparam int NS_W = $clog2(MAX_SIDE + 1),
    localparam int NC_W = $clog2(MAX_CHANNELS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [NB_W-1:0]       nb,
    output logic [NS_W-1:0]       nh,
    output logic [NS_W-1:0]       nw,
    output logic [NC_W-1:0]       nc,
    output mode_t                 mode
);

    logic [BATCH_CFG_W-1:0] batch_count_reg;
    logic [SIDE_CFG_W-1:0]  height_reg;
    logic [SIDE_CFG_W-1:0]  width_reg;
    logic [CHAN_CFG_W-1:0]  channels_reg;
    logic                   channel_last_reg;
    logic [SYM_W-1:0]       symmetry_reg;
    logic                   reverse_mode_reg;

    logic     wr_en;
    reg_idx_t reg_sel;
    logic     tr;
    logic     fx_raw;
    logic     fy_raw;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[4:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_count_reg  <= BATCH_CFG_W'(1);
            height_reg       <= SIDE_CFG_W'(1);
            width_reg        <= SIDE_CFG_W'(1);
            channels_reg     <= CHAN_CFG_W'(1);
            channel_last_reg <= 1'b0;
            symmetry_reg     <= '0;
            reverse_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BATCH_COUNT:  batch_count_reg  <= pwdata[BATCH_CFG_W-1:0];
                REG_HEIGHT:       height_reg       <= pwdata[SIDE_CFG_W-1:0];
                REG_WIDTH:        width_reg        <= pwdata[SIDE_CFG_W-1:0];
                REG_CHANNELS:     channels_reg     <= pwdata[CHAN_CFG_W-1:0];
                REG_CHANNEL_LAST: channel_last_reg <= pwdata[0];
                REG_SYMMETRY:     symmetry_reg     <= pwdata[SYM_W-1:0];
                REG_REVERSE_MODE: reverse_mode_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_BATCH_COUNT:  prdata = APB_DATA_W'(batch_count_reg);
            REG_HEIGHT:       prdata = APB_DATA_W'(height_reg);
            REG_WIDTH:        prdata = APB_DATA_W'(width_reg);
            REG_CHANNELS:     prdata = APB_DATA_W'(channels_reg);
            REG_CHANNEL_LAST: prdata = APB_DATA_W'(channel_last_reg);
            REG_SYMMETRY:     prdata = APB_DATA_W'(symmetry_reg);
            REG_REVERSE_MODE: prdata = APB_DATA_W'(reverse_mode_reg);
            default:          prdata = '0;
        endcase
    end

    // Size clamping: zero counts as one, anything above the limit as the limit
    always_comb
    begin
        if (batch_count_reg == '0)
            nb = NB_W'(1);
        else if (32'(batch_count_reg) > 32'(MAX_BATCH))
            nb = NB_W'(MAX_BATCH);
        else
            nb = NB_W'(batch_count_reg);

        if (height_reg == '0)
            nh = NS_W'(1);
        else if (32'(height_reg) > 32'(MAX_SIDE))
            nh = NS_W'(MAX_SIDE);
        else
            nh = NS_W'(height_reg);

        if (width_reg == '0)
            nw = NS_W'(1);
        else if (32'(width_reg) > 32'(MAX_SIDE))
            nw = NS_W'(MAX_SIDE);
        else
            nw = NS_W'(width_reg);

        if (channels_reg == '0)
            nc = NC_W'(1);
        else if (32'(channels_reg) > 32'(MAX_CHANNELS))
            nc = NC_W'(MAX_CHANNELS);
        else
            nc = NC_W'(channels_reg);
    end

    // Symmetry decode; transpose applies only when height equals width, and forward transpose swaps the flips
    assign tr     = ((symmetry_reg & SYM_TRANSPOSE) != '0) && (nh == nw);
    assign fx_raw = (symmetry_reg & SYM_FLIP_X) != '0;
    assign fy_raw = (symmetry_reg & SYM_FLIP_Y) != '0;

    always_comb
    begin
        mode.channel_last = channel_last_reg;
        mode.tr           = tr;
        if (tr && !reverse_mode_reg)
        begin
            mode.fx = fy_raw;
            mode.fy = fx_raw;
        end
        else
        begin
            mode.fx = fx_raw;
            mode.fy = fy_raw;
        end
    end

endmodule

// ===== rtl/core/tdca_coord.sv =====
// ---------------------------------------------------------------------------
// tdca_coord
// Source position counters and the first pipeline stage: mirrored and
// transposed coordinates in Horner order for the active layout.
// ---------------------------------------------------------------------------
module tdca_coord
    import tdca_pkg::*;
#(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int NB_W = $clog2(MAX_BATCH + 1),
    localparam int NS_W = $clog2(MAX_SIDE + 1),
    localparam int NC_W = $clog2(MAX_CHANNELS + 1),
    localparam int CB_W = ctr_w(MAX_BATCH),
    localparam int CS_W = ctr_w(MAX_SIDE),
    localparam int CC_W = ctr_w(MAX_CHANNELS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] data_in,
    output logic              in_stall,
    input  logic              s2_ready,
    input  logic [NB_W-1:0]   nb,
    input  logic [NS_W-1:0]   nh,
    input  logic [NS_W-1:0]   nw,
    input  logic [NC_W-1:0]   nc,
    input  mode_t             mode,
    output logic              s1_valid,
    output logic [CB_W-1:0]   s1_b,
    output logic [IDX_W-1:0]  s1_x,
    output logic [IDX_W-1:0]  s1_y,
    output logic [IDX_W-1:0]  s1_z,
    output logic [DATA_W-1:0] s1_value,
    output logic              s1_last
);

    logic [CB_W-1:0] b_reg,  b_next;
    logic [CS_W-1:0] r_reg,  r_next;
    logic [CS_W-1:0] c_reg,  c_next;
    logic [CC_W-1:0] ch_reg, ch_next;

    logic              s1_valid_reg;
    logic [CB_W-1:0]   s1_b_reg;
    logic [IDX_W-1:0]  s1_x_reg, s1_y_reg, s1_z_reg;
    logic [DATA_W-1:0] s1_value_reg;
    logic              s1_last_reg;

    logic             accept;
    logic             wrap_b, wrap_r, wrap_c, wrap_ch;
    logic [CB_W-1:0]  b_inc;
    logic [CS_W-1:0]  r_inc, c_inc;
    logic [CC_W-1:0]  ch_inc;
    logic [CS_W-1:0]  row_src, col_src;
    logic [IDX_W-1:0] rr, cc;

    assign in_stall = s1_valid_reg && !s2_ready;
    assign accept   = in_valid && !in_stall;

    // A counter wraps when it is at or above its size minus one
    assign wrap_b  = (32'(b_reg)  + 32'd1) >= 32'(nb);
    assign wrap_r  = (32'(r_reg)  + 32'd1) >= 32'(nh);
    assign wrap_c  = (32'(c_reg)  + 32'd1) >= 32'(nw);
    assign wrap_ch = (32'(ch_reg) + 32'd1) >= 32'(nc);

    assign b_inc  = wrap_b  ? '0 : CB_W'(b_reg + 1'b1);
    assign r_inc  = wrap_r  ? '0 : CS_W'(r_reg + 1'b1);
    assign c_inc  = wrap_c  ? '0 : CS_W'(c_reg + 1'b1);
    assign ch_inc = wrap_ch ? '0 : CC_W'(ch_reg + 1'b1);

    // Counter stepping in layout order
    always_comb
    begin
        b_next  = b_reg;
        r_next  = r_reg;
        c_next  = c_reg;
        ch_next = ch_reg;
        if (mode.channel_last)
        begin
            ch_next = ch_inc;
            if (wrap_ch)
                c_next = c_inc;
            if (wrap_ch && wrap_c)
                r_next = r_inc;
            if (wrap_ch && wrap_c && wrap_r)
                b_next = b_inc;
        end
        else
        begin
            c_next = c_inc;
            if (wrap_c)
                r_next = r_inc;
            if (wrap_c && wrap_r)
                ch_next = ch_inc;
            if (wrap_c && wrap_r && wrap_ch)
                b_next = b_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg  <= '0;
            r_reg  <= '0;
            c_reg  <= '0;
            ch_reg <= '0;
        end
        else if (accept)
        begin
            b_reg  <= b_next;
            r_reg  <= r_next;
            c_reg  <= c_next;
            ch_reg <= ch_next;
        end
    end

    // Destination row and column, modulo 2^24
    assign row_src = mode.tr ? c_reg : r_reg;
    assign col_src = mode.tr ? r_reg : c_reg;
    assign rr = mode.fy ? IDX_W'(nh) - IDX_W'(1) - IDX_W'(row_src) : IDX_W'(row_src);
    assign cc = mode.fx ? IDX_W'(nw) - IDX_W'(1) - IDX_W'(col_src) : IDX_W'(col_src);

    // Stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_valid_reg || s2_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_b_reg     <= b_reg;
            s1_value_reg <= data_in;
            s1_last_reg  <= wrap_b && wrap_r && wrap_c && wrap_ch;
            if (mode.channel_last)
            begin
                s1_x_reg <= rr;
                s1_y_reg <= cc;
                s1_z_reg <= IDX_W'(ch_reg);
            end
            else
            begin
                s1_x_reg <= IDX_W'(ch_reg);
                s1_y_reg <= rr;
                s1_z_reg <= cc;
            end
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_b     = s1_b_reg;
    assign s1_x     = s1_x_reg;
    assign s1_y     = s1_y_reg;
    assign s1_z     = s1_z_reg;
    assign s1_value = s1_value_reg;
    assign s1_last  = s1_last_reg;

endmodule

// ===== rtl/core/tdca_index.sv =====
// ---------------------------------------------------------------------------
// tdca_index
// Three multiply-add stages forming ((b*A + x)*B + y)*C + z, the last of
// which is the output register.
// ---------------------------------------------------------------------------
module tdca_index
    import tdca_pkg::*;
#(
    parameter int MAX_BATCH    = DEF_MAX_BATCH,
    parameter int MAX_SIDE     = DEF_MAX_SIDE,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int NS_W = $clog2(MAX_SIDE + 1),
    localparam int NC_W = $clog2(MAX_CHANNELS + 1),
    localparam int CB_W = ctr_w(MAX_BATCH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  logic [CB_W-1:0]   s1_b,
    input  logic [IDX_W-1:0]  s1_x,
    input  logic [IDX_W-1:0]  s1_y,
    input  logic [IDX_W-1:0]  s1_z,
    input  logic [DATA_W-1:0] s1_value,
    input  logic              s1_last,
    output logic              s2_ready,
    input  logic [NS_W-1:0]   nh,
    input  logic [NS_W-1:0]   nw,
    input  logic [NC_W-1:0]   nc,
    input  mode_t             mode,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  dest_index,
    output logic [DATA_W-1:0] value_out,
    output logic              last_item
);

    logic              s2_valid_reg;
    logic [IDX_W-1:0]  s2_t_reg, s2_y_reg, s2_z_reg;
    logic [DATA_W-1:0] s2_value_reg;
    logic              s2_last_reg;

    logic              s3_valid_reg;
    logic [IDX_W-1:0]  s3_t_reg, s3_z_reg;
    logic [DATA_W-1:0] s3_value_reg;
    logic              s3_last_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  dest_index_reg;
    logic [DATA_W-1:0] value_out_reg;
    logic              last_item_reg;

    logic             out_ready, s3_ready;
    logic [IDX_W-1:0] mul_a, mul_b, mul_c;

    // Back-pressure chain; empty stages always accept
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;

    // Strides per layout: NHWC uses H, W, C; NCHW uses C, H, W
    assign mul_a = mode.channel_last ? IDX_W'(nh) : IDX_W'(nc);
    assign mul_b = mode.channel_last ? IDX_W'(nw) : IDX_W'(nh);
    assign mul_c = mode.channel_last ? IDX_W'(nc) : IDX_W'(nw);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= s1_valid;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 2: b*A + x
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            s2_t_reg     <= IDX_W'(IDX_W'(s1_b) * mul_a) + s1_x;
            s2_y_reg     <= s1_y;
            s2_z_reg     <= s1_z;
            s2_value_reg <= s1_value;
            s2_last_reg  <= s1_last;
        end
    end

    // Stage 3: t*B + y
    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_t_reg     <= IDX_W'(s2_t_reg * mul_b) + s2_y_reg;
            s3_z_reg     <= s2_z_reg;
            s3_value_reg <= s2_value_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // Output register: t*C + z
    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            dest_index_reg <= IDX_W'(s3_t_reg * mul_c) + s3_z_reg;
            value_out_reg  <= s3_value_reg;
            last_item_reg  <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_index = dest_index_reg;
    assign value_out  = value_out_reg;
    assign last_item  = last_item_reg;

endmodule
